FILE: rtl/core/apsc_pkg.sv
// Shared types, constants and register map of the peak step counter.
package apsc_pkg;

	localparam int BLOCK_LEN = 256;
	localparam int POS_W     = $clog2(BLOCK_LEN);
	localparam int GAP_W     = (POS_W > 8) ? POS_W : 8;
	localparam int ADDR_W    = 5;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_RISE = 2'd1,
		KIND_FALL = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_SLOPE    = 3'd0,
		REG_HIGH     = 3'd1,
		REG_LOW      = 3'd2,
		REG_AMP_DROP = 3'd3,
		REG_MIN_GAP  = 3'd4,
		REG_MAX_GAP  = 3'd5
	} reg_idx_t;

	localparam logic [14:0]        SLOPE_RST    = 15'd20;
	localparam logic signed [15:0] HIGH_RST     = 16'sd1000;
	localparam logic signed [15:0] LOW_RST      = -16'sd1000;
	localparam logic [14:0]        AMP_DROP_RST = 15'd500;
	localparam logic [7:0]         MIN_GAP_RST  = 8'd5;
	localparam logic [7:0]         MAX_GAP_RST  = 8'd50;

	typedef struct packed {
		logic [14:0]        slope_threshold;
		logic signed [15:0] high_threshold;
		logic signed [15:0] low_threshold;
		logic [14:0]        amplitude_drop_threshold;
		logic [7:0]         min_gap;
		logic [7:0]         max_gap;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   pos;
		logic signed [15:0] value;
		logic               last;
	} item_t;

endpackage

FILE: rtl/core/apsc_in_if.sv
// Sample request channel: valid/ready handshake with sample payload.
interface apsc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               last_in_block;

	modport source (output valid, output sample, output last_in_block, input ready);
	modport sink (input valid, input sample, input last_in_block, output ready);
endinterface

FILE: rtl/core/apsc_out_if.sv
// Result request channel: valid/ready handshake with step count payload.
interface apsc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] step_count;
	logic [1:0]  peak_kind;
	logic        block_done;

	modport source (output valid, output step_count, output peak_kind, output block_done,
		input ready);
	modport sink (input valid, input step_count, input peak_kind, input block_done,
		output ready);
endinterface

FILE: rtl/core/accel_peak_step_counter.sv
// Top level of the peak step counter: register port, front, queue and back.
//
//  channel   dir  handshake       payload
//  samples   in   valid/ready     sample[15:0] signed, last_in_block
//  counts    out  valid/ready     step_count[31:0], peak_kind[1:0], block_done
//  apb       in   psel/penable    paddr[4:0], pwdata[31:0], prdata[31:0]
//
//  One sample per cycle unless the queue is full; results are registered.
//  The front classifies a four-sample window plus the input, the back scores pairs.
//  A two-entry queue plus the result register absorb stalls on either side.
//  Reset clears window, position, held peaks and step count and loads defaults.
module accel_peak_step_counter
	import apsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	apsc_in_if.sink           samples,
	apsc_out_if.source        counts,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t  cfg_q;
	logic  full;
	logic  empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t pop_item;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slope_threshold          <= SLOPE_RST;
			cfg_q.high_threshold           <= HIGH_RST;
			cfg_q.low_threshold            <= LOW_RST;
			cfg_q.amplitude_drop_threshold <= AMP_DROP_RST;
			cfg_q.min_gap                  <= MIN_GAP_RST;
			cfg_q.max_gap                  <= MAX_GAP_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_SLOPE:    cfg_q.slope_threshold          <= pwdata[14:0];
				REG_HIGH:     cfg_q.high_threshold           <= pwdata[15:0];
				REG_LOW:      cfg_q.low_threshold            <= pwdata[15:0];
				REG_AMP_DROP: cfg_q.amplitude_drop_threshold <= pwdata[14:0];
				REG_MIN_GAP:  cfg_q.min_gap                  <= pwdata[7:0];
				REG_MAX_GAP:  cfg_q.max_gap                  <= pwdata[7:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_SLOPE:    prdata = {17'd0, cfg_q.slope_threshold};
			REG_HIGH:     prdata = {{16{cfg_q.high_threshold[15]}}, cfg_q.high_threshold};
			REG_LOW:      prdata = {{16{cfg_q.low_threshold[15]}}, cfg_q.low_threshold};
			REG_AMP_DROP: prdata = {17'd0, cfg_q.amplitude_drop_threshold};
			REG_MIN_GAP:  prdata = {24'd0, cfg_q.min_gap};
			REG_MAX_GAP:  prdata = {24'd0, cfg_q.max_gap};
			default:      prdata = '0;
		endcase
	end

	apsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.cfg       (cfg_q),
		.full      (full),
		.push      (push),
		.push_item (push_item)
	);

	apsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	apsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.empty    (empty),
		.pop_item (pop_item),
		.pop      (pop),
		.counts   (counts)
	);

endmodule

FILE: rtl/core/apsc_front.sv
// Front end: sample window, block position and peak classification.
module apsc_front
	import apsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	apsc_in_if.sink    samples,
	input  cfg_t       cfg,
	input  logic       full,
	output logic       push,
	output item_t      push_item
);

	logic signed [15:0] win_q [4];
	logic [POS_W-1:0]   pos_q;
	logic signed [15:0] a2, a1, c, b1, b2;
	logic signed [15:0] slope;
	logic               last;
	logic               rise, fall;
	kind_t              kind;

	function automatic logic steep(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic signed [15:0] thr);
		logic signed [15:0] d;
		d = x - y;
		return d > thr;
	endfunction

	assign a2    = win_q[0];
	assign a1    = win_q[1];
	assign c     = win_q[2];
	assign b1    = win_q[3];
	assign b2    = samples.sample;
	assign slope = $signed({1'b0, cfg.slope_threshold});

	assign last = samples.last_in_block || (pos_q == POS_W'(BLOCK_LEN - 1));

	always_comb begin
		rise = steep(a1, a2, slope) && steep(c, a1, slope) && steep(c, b1, slope) &&
			steep(b1, b2, slope) && (a1 > 16'sd0) && (c > cfg.high_threshold) &&
			(b1 > 16'sd0);
		fall = steep(a2, a1, slope) && steep(a1, c, slope) && steep(b1, c, slope) &&
			steep(b2, b1, slope) && (a1 < cfg.low_threshold) &&
			(c < cfg.low_threshold) && (b1 < cfg.low_threshold);
		kind = KIND_NONE;
		if (pos_q >= POS_W'(4)) begin
			if (rise) begin
				kind = KIND_RISE;
			end else if (fall) begin
				kind = KIND_FALL;
			end
		end
	end

	assign samples.ready   = !full;
	assign push            = samples.valid && !full;
	assign push_item.kind  = kind;
	assign push_item.pos   = pos_q - POS_W'(2);
	assign push_item.value = c;
	assign push_item.last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < 4; i++) begin
				win_q[i] <= '0;
			end
		end else if (push) begin
			if (last) begin
				pos_q <= '0;
				for (int i = 0; i < 4; i++) begin
					win_q[i] <= '0;
				end
			end else begin
				pos_q    <= pos_q + POS_W'(1);
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= win_q[3];
				win_q[3] <= samples.sample;
			end
		end
	end

endmodule

FILE: rtl/core/apsc_queue.sv
// Two-entry queue between classification and scoring.
module apsc_queue
	import apsc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/apsc_back.sv
// Back end: held peaks, pair scoring, step count and result register.
module apsc_back
	import apsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       empty,
	input  item_t      pop_item,
	output logic       pop,
	apsc_out_if.source counts
);

	kind_t              kinds_q [2];
	logic [POS_W-1:0]   poss_q [2];
	logic signed [15:0] vals_q [2];
	logic [1:0]         held_q;
	logic [31:0]        steps_q;
	logic               valid_q;
	logic [31:0]        count_q;
	kind_t              kind_q;
	logic               done_q;

	logic [POS_W-1:0]   gap;
	logic [GAP_W-1:0]   gap_x;
	logic               gap_ok;
	logic signed [15:0] amp;
	logic               amp_ok;
	logic [1:0]         pair_add;
	kind_t              last_kind;
	logic               end_add;
	logic [31:0]        steps_n;
	logic               peak;

	assign peak   = (pop_item.kind != KIND_NONE);
	assign gap    = poss_q[1] - poss_q[0];
	assign gap_x  = GAP_W'(gap);
	assign gap_ok = (gap_x > GAP_W'(cfg.min_gap)) && (gap_x < GAP_W'(cfg.max_gap));
	assign amp    = vals_q[0] - vals_q[1];
	assign amp_ok = amp > $signed({1'b0, cfg.amplitude_drop_threshold});

	always_comb begin
		pair_add = 2'd0;
		if (peak && held_q == 2'd2) begin
			if (kinds_q[0] == KIND_RISE) begin
				if (kinds_q[1] == KIND_FALL && gap_ok && amp_ok) begin
					pair_add = 2'd2;
				end
			end else if (kinds_q[0] == KIND_FALL && kinds_q[1] == KIND_FALL && gap_ok) begin
				pair_add = 2'd1;
			end
		end
		if (peak) begin
			last_kind = pop_item.kind;
		end else if (held_q == 2'd2) begin
			last_kind = kinds_q[1];
		end else if (held_q == 2'd1) begin
			last_kind = kinds_q[0];
		end else begin
			last_kind = KIND_NONE;
		end
		end_add = pop_item.last && (last_kind == KIND_RISE);
		steps_n = steps_q + 32'(pair_add) + 32'(end_add);
	end

	assign pop               = !empty && (!valid_q || counts.ready);
	assign counts.valid      = valid_q;
	assign counts.step_count = count_q;
	assign counts.peak_kind  = kind_q;
	assign counts.block_done = done_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			count_q <= steps_n;
			kind_q  <= pop_item.kind;
			done_q  <= pop_item.last;
			if (peak) begin
				if (held_q == 2'd0) begin
					kinds_q[0] <= pop_item.kind;
					poss_q[0]  <= pop_item.pos;
					vals_q[0]  <= pop_item.value;
				end else begin
					if (held_q == 2'd2) begin
						kinds_q[0] <= kinds_q[1];
						poss_q[0]  <= poss_q[1];
						vals_q[0]  <= vals_q[1];
					end
					kinds_q[1] <= pop_item.kind;
					poss_q[1]  <= pop_item.pos;
					vals_q[1]  <= pop_item.value;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			held_q  <= '0;
			steps_q <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				steps_q <= steps_n;
				if (pop_item.last) begin
					held_q <= '0;
				end else if (peak && held_q != 2'd2) begin
					held_q <= held_q + 2'd1;
				end
			end else if (counts.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
